FILE: hdl/handheld_bus_decoder_mbc1_defines.svh
// Assertion macros shared by the bus decoder RTL.
`ifndef HANDHELD_BUS_DECODER_MBC1_DEFINES_SVH
`define HANDHELD_BUS_DECODER_MBC1_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property while out of reset.
`define HBD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bus decoder check failed");
// Check a property on every edge, reset included.
`define HBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bus decoder check failed");
`else
`define HBD_ASSERT(lbl, clk, rstn, prop)
`define HBD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/hbd_mbc1_pkg.sv
// Types and constants of the MBC1 bus decoder.
package hbd_mbc1_pkg;

    // Input word of one CPU bus access
    typedef struct packed {
        logic        req_type;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
        logic        vram_locked;
        logic        oam_locked;
        logic [7:0]  direction_keys;
        logic [7:0]  action_keys;
    } t_req;

    // Result word
    typedef struct packed {
        logic [2:0]  target;
        logic [21:0] mem_offset;
        logic        mem_write;
        logic [7:0]  read_byte;
    } t_rsp;

    // Access classes found by the front end
    typedef enum logic [3:0] {
        OP_MBC,
        OP_ROM,
        OP_VRAM,
        OP_CRAM,
        OP_WRAM,
        OP_OAM,
        OP_DROP,
        OP_IO,
        OP_HRAM,
        OP_IE
    } t_op;

    // Classified access held in the queue
    typedef struct packed {
        t_op         op;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  dir_keys;
        logic [7:0]  act_keys;
    } t_cmd;

    // Target codes
    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_BOOT = 3'd1;
    localparam logic [2:0] TGT_ROM  = 3'd2;
    localparam logic [2:0] TGT_VRAM = 3'd3;
    localparam logic [2:0] TGT_CRAM = 3'd4;
    localparam logic [2:0] TGT_WRAM = 3'd5;
    localparam logic [2:0] TGT_OAM  = 3'd6;

    // Configuration register indexes
    localparam logic CFG_BANK_MODE  = 1'b0;
    localparam logic CFG_HAS_MAPPER = 1'b1;

    // I/O register offsets handled specially
    localparam logic [6:0] IO_JOYP = 7'h00;
    localparam logic [6:0] IO_SC   = 7'h02;
    localparam logic [6:0] IO_IF   = 7'h0F;
    localparam logic [6:0] IO_BOOT = 7'h50;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] BYTE_FF    = 8'hFF;

endpackage

FILE: hdl/hbd_mbc1_front.sv
// Front end: classifies a bus access by address region and lock inputs.
module hbd_mbc1_front (
    input  hbd_mbc1_pkg::t_req i_req,
    output hbd_mbc1_pkg::t_cmd o_cmd
);

    logic [15:0] a;

    assign a = i_req.bus_address;

    // Sort the address into its region; fold the video locks in here
    always_comb begin
        o_cmd.wr       = i_req.req_type;
        o_cmd.addr     = a;
        o_cmd.data     = i_req.write_byte;
        o_cmd.dir_keys = i_req.direction_keys;
        o_cmd.act_keys = i_req.action_keys;
        priority if (a <= 16'h7FFF) begin
            o_cmd.op = i_req.req_type ? hbd_mbc1_pkg::OP_MBC : hbd_mbc1_pkg::OP_ROM;
        end else if (a <= 16'h9FFF) begin
            o_cmd.op = i_req.vram_locked ? hbd_mbc1_pkg::OP_DROP : hbd_mbc1_pkg::OP_VRAM;
        end else if (a <= 16'hBFFF) begin
            o_cmd.op = hbd_mbc1_pkg::OP_CRAM;
        end else if (a <= 16'hFDFF) begin
            o_cmd.op = hbd_mbc1_pkg::OP_WRAM;
        end else if (a <= 16'hFE9F) begin
            o_cmd.op = i_req.oam_locked ? hbd_mbc1_pkg::OP_DROP : hbd_mbc1_pkg::OP_OAM;
        end else if (a <= 16'hFEFF) begin
            o_cmd.op = hbd_mbc1_pkg::OP_DROP;
        end else if (a <= 16'hFF7F) begin
            o_cmd.op = hbd_mbc1_pkg::OP_IO;
        end else if (a <= 16'hFFFE) begin
            o_cmd.op = hbd_mbc1_pkg::OP_HRAM;
        end else begin
            o_cmd.op = hbd_mbc1_pkg::OP_IE;
        end
    end

endmodule

FILE: hdl/hbd_mbc1_queue.sv
// Two-entry queue between the front end and the back end.
module hbd_mbc1_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hbd_mbc1_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output hbd_mbc1_pkg::t_cmd o_cmd
);

    hbd_mbc1_pkg::t_cmd r_slot [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    // Count words in flight
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_cmd;
    end

endmodule

FILE: hdl/hbd_mbc1_back.sv
// Back end: bank registers, I/O and high-RAM store, result formatting.
module hbd_mbc1_back #(
    parameter int ROM_BANK_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic               i_cfg_data,
    input  logic               i_cmd_valid,
    input  hbd_mbc1_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hbd_mbc1_pkg::t_rsp o_out_data
);

    localparam logic [7:0] BANK_MASK = 8'((1 << ROM_BANK_BITS) - 1);

    // Configuration and bank state
    logic       r_bank_mode, r_has_mapper;
    logic [4:0] r_rom_bank;
    logic [1:0] r_ram_bank;
    logic [3:0] r_ram_en;
    logic       r_boot_on;
    logic [7:0] r_irq_en, r_irq_flag;

    // I/O store (lower half) and high RAM (upper half)
    logic [7:0] r_mem [256];
    logic       r_vld [256];
    logic [7:0] r_rdq;
    logic       r_vldq;

    // Result stage
    logic        r_b2_valid;
    logic [2:0]  r_tgt;
    logic [21:0] r_off;
    logic        r_mw;
    logic [7:0]  r_imm;
    logic        r_use_mem, r_joy;
    logic [7:0]  r_dir, r_act;

    // Issue-stage decisions
    logic        adv;
    logic [2:0]  tgt;
    logic [21:0] off;
    logic        mw;
    logic [7:0]  imm;
    logic        use_mem, joy, mem_we;
    logic [7:0]  mem_wd;
    logic [7:0]  idx;
    logic [6:0]  bank7;
    logic [7:0]  bank_m;
    logic [4:0]  low5;
    logic [6:0]  r_io;
    logic [7:0]  rdata, joy_v;

    assign adv   = i_cmd_valid && (!r_b2_valid || i_out_ready);
    assign o_pop = adv;
    assign r_io  = i_cmd.addr[6:0];
    assign idx   = {(i_cmd.op == hbd_mbc1_pkg::OP_HRAM), r_io};
    assign low5  = (i_cmd.data[4:0] == 5'd0) ? 5'd1 : i_cmd.data[4:0];

    // Form the switched ROM bank; zero banks step up by one
    always_comb begin
        bank7 = {r_bank_mode ? r_ram_bank : 2'd0, r_rom_bank};
        if (bank7[4:0] == 5'd0) bank7 = bank7 + 7'd1;
        bank_m = {1'b0, bank7} & BANK_MASK;
    end

    // Decide the result of the word at the queue head
    always_comb begin
        tgt     = hbd_mbc1_pkg::TGT_NONE;
        off     = '0;
        mw      = 1'b0;
        imm     = 8'd0;
        use_mem = 1'b0;
        joy     = 1'b0;
        mem_we  = 1'b0;
        mem_wd  = i_cmd.data;
        case (i_cmd.op)
            hbd_mbc1_pkg::OP_MBC: begin
            end
            hbd_mbc1_pkg::OP_ROM: begin
                if (r_boot_on && i_cmd.addr[15:8] == 8'd0) begin
                    tgt = hbd_mbc1_pkg::TGT_BOOT;
                    off = {6'd0, i_cmd.addr};
                end else if (!i_cmd.addr[14] || !r_has_mapper) begin
                    tgt = hbd_mbc1_pkg::TGT_ROM;
                    off = {6'd0, i_cmd.addr};
                end else begin
                    tgt = hbd_mbc1_pkg::TGT_ROM;
                    off = {bank_m, i_cmd.addr[13:0]};
                end
            end
            hbd_mbc1_pkg::OP_VRAM: begin
                tgt = hbd_mbc1_pkg::TGT_VRAM;
                off = {9'd0, i_cmd.addr[12:0]};
                mw  = i_cmd.wr;
            end
            hbd_mbc1_pkg::OP_CRAM: begin
                if (r_ram_en != hbd_mbc1_pkg::RAM_EN_KEY) begin
                    imm = i_cmd.wr ? 8'd0 : hbd_mbc1_pkg::BYTE_FF;
                end else begin
                    tgt = hbd_mbc1_pkg::TGT_CRAM;
                    off = {7'd0, r_bank_mode ? r_ram_bank : 2'd0, i_cmd.addr[12:0]};
                    mw  = i_cmd.wr;
                end
            end
            hbd_mbc1_pkg::OP_WRAM: begin
                tgt = hbd_mbc1_pkg::TGT_WRAM;
                off = {9'd0, i_cmd.addr[12:0]};
                mw  = i_cmd.wr;
            end
            hbd_mbc1_pkg::OP_OAM: begin
                tgt = hbd_mbc1_pkg::TGT_OAM;
                off = {14'd0, i_cmd.addr[7:0]};
                mw  = i_cmd.wr;
            end
            hbd_mbc1_pkg::OP_DROP: begin
                imm = i_cmd.wr ? 8'd0 : hbd_mbc1_pkg::BYTE_FF;
            end
            hbd_mbc1_pkg::OP_IO: begin
                if (!i_cmd.wr) begin
                    if (r_io == hbd_mbc1_pkg::IO_IF) begin
                        imm = r_irq_flag;
                    end else begin
                        use_mem = 1'b1;
                        joy     = (r_io == hbd_mbc1_pkg::IO_JOYP);
                    end
                end else if (r_io == hbd_mbc1_pkg::IO_JOYP) begin
                    mem_we = 1'b1;
                    mem_wd = (i_cmd.data & 8'h30) | 8'hC0;
                end else if (r_io == hbd_mbc1_pkg::IO_SC) begin
                    mem_we = 1'b1;
                    mem_wd = i_cmd.data & 8'h7F;
                end else if (r_io != hbd_mbc1_pkg::IO_IF && r_io != hbd_mbc1_pkg::IO_BOOT) begin
                    mem_we = 1'b1;
                end
            end
            hbd_mbc1_pkg::OP_HRAM: begin
                if (i_cmd.wr) mem_we = 1'b1;
                else          use_mem = 1'b1;
            end
            hbd_mbc1_pkg::OP_IE: begin
                if (!i_cmd.wr) imm = r_irq_en;
            end
            default: begin
            end
        endcase
    end

    // Update configuration and bank registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_mode  <= 1'b0;
            r_has_mapper <= 1'b1;
            r_rom_bank   <= 5'd0;
            r_ram_bank   <= 2'd0;
            r_ram_en     <= 4'd0;
            r_boot_on    <= 1'b1;
            r_irq_en     <= 8'd0;
            r_irq_flag   <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == hbd_mbc1_pkg::CFG_BANK_MODE) r_bank_mode <= i_cfg_data;
                else r_has_mapper <= i_cfg_data;
            end
            if (adv && i_cmd.wr) begin
                unique case (i_cmd.op)
                    hbd_mbc1_pkg::OP_MBC: begin
                        unique case (i_cmd.addr[14:13])
                            2'd0:    r_ram_en   <= i_cmd.data[3:0];
                            2'd1:    r_rom_bank <= low5;
                            2'd2:    r_ram_bank <= i_cmd.data[1:0];
                            default: begin
                            end
                        endcase
                    end
                    hbd_mbc1_pkg::OP_IO: begin
                        if (r_io == hbd_mbc1_pkg::IO_SC && i_cmd.data[7]) begin
                            r_irq_flag <= r_irq_flag | 8'h08;
                        end
                        if (r_io == hbd_mbc1_pkg::IO_IF)   r_irq_flag <= i_cmd.data;
                        if (r_io == hbd_mbc1_pkg::IO_BOOT) r_boot_on  <= 1'b0;
                    end
                    hbd_mbc1_pkg::OP_IE: r_irq_en <= i_cmd.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Mark written entries; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 256; k++) r_vld[k] <= 1'b0;
        end else if (adv && mem_we) begin
            r_vld[idx] <= 1'b1;
        end
    end

    // Store memory with registered read
    always_ff @(posedge i_clk) begin
        if (adv && mem_we) r_mem[idx] <= mem_wd;
        if (adv) begin
            r_rdq  <= r_mem[idx];
            r_vldq <= r_vld[idx];
        end
    end

    // Result stage handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (adv) begin
            r_b2_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_b2_valid <= 1'b0;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tgt     <= tgt;
            r_off     <= off;
            r_mw      <= mw;
            r_imm     <= imm;
            r_use_mem <= use_mem;
            r_joy     <= joy;
            r_dir     <= i_cmd.dir_keys;
            r_act     <= i_cmd.act_keys;
        end
    end

    // Merge stored data and the joypad keys
    always_comb begin
        rdata = r_vldq ? r_rdq : 8'd0;
        joy_v = rdata | 8'h0F;
        if (!rdata[4]) joy_v = joy_v & r_dir;
        if (!rdata[5]) joy_v = joy_v & r_act;
        joy_v = joy_v | 8'hC0;
    end

    assign o_out_valid          = r_b2_valid;
    assign o_out_data.target    = r_tgt;
    assign o_out_data.mem_offset = r_off;
    assign o_out_data.mem_write = r_mw;
    assign o_out_data.read_byte = r_use_mem ? (r_joy ? joy_v : rdata) : r_imm;

endmodule

FILE: hdl/handheld_bus_decoder_mbc1.sv
// Top level of the MBC1 bus decoder: front end, queue and back end.
// One CPU bus access per clock is accepted and answered with exactly one result word,
// in order. An accepted access is held in the queue until the back end issues it,
// which loads the registered store read and the result register together. Sustained
// rate is one word per cycle while the output does not stall. While the output stalls the
// two-entry queue fills and o_in_ready drops. The I/O and high-RAM store needs no
// clearing pass after reset: each of its 256 entries carries a valid bit.
`include "handheld_bus_decoder_mbc1_defines.svh"
module handheld_bus_decoder_mbc1 #(
    parameter int ROM_BANK_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hbd_mbc1_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hbd_mbc1_pkg::t_rsp o_out_data
);

    hbd_mbc1_pkg::t_cmd cmd_in, cmd_q;
    logic full, q_valid, pop;

    assign o_in_ready = !full;

    hbd_mbc1_front u_front (
        .i_req (i_in_data),
        .o_cmd (cmd_in)
    );

    hbd_mbc1_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !full),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_q)
    );

    hbd_mbc1_back #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (cmd_q),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `HBD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)
    `HBD_ASSERT(a_none_no_wr, i_clk, i_rst_n, o_out_valid && o_out_data.target == hbd_mbc1_pkg::TGT_NONE |-> !o_out_data.mem_write && o_out_data.mem_offset == 22'd0)
    `HBD_ASSERT(a_rom_ro, i_clk, i_rst_n, o_out_valid && (o_out_data.target == hbd_mbc1_pkg::TGT_ROM || o_out_data.target == hbd_mbc1_pkg::TGT_BOOT) |-> !o_out_data.mem_write)
    `HBD_ASSERT(a_ext_no_rd, i_clk, i_rst_n, o_out_valid && o_out_data.target != hbd_mbc1_pkg::TGT_NONE |-> o_out_data.read_byte == 8'd0)

endmodule

FILE: bench/handheld_bus_decoder_mbc1_checker.sv
// Checker for the MBC1 bus decoder: predicts each result word and compares it.
module handheld_bus_decoder_mbc1_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  hbd_mbc1_pkg::t_req i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  hbd_mbc1_pkg::t_rsp i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic               mode_q;
    logic               mapper_q;
    logic [7:0]         rom_bank;
    logic [1:0]         ram_bank;
    logic [3:0]         ram_en;
    logic               boot_on;
    logic [7:0]         io_regs [128];
    logic [7:0]         hram [127];
    logic [7:0]         ie_reg;
    hbd_mbc1_pkg::t_rsp expected_words [$];

    assign o_pending = expected_words.size();

    function automatic hbd_mbc1_pkg::t_rsp mk(logic [2:0] t, logic [21:0] o, logic w,
                                              logic [7:0] r);
        hbd_mbc1_pkg::t_rsp x;
        x.target = t; x.mem_offset = o; x.mem_write = w; x.read_byte = r;
        return x;
    endfunction

    // Decode one access against the shadow state, updating it as the block would
    function automatic hbd_mbc1_pkg::t_rsp decode_access(hbd_mbc1_pkg::t_req q);
        logic [15:0]        a;
        logic [7:0]         d;
        logic [7:0]         v;
        logic [6:0]         r;
        logic [7:0]         bank;
        logic               wr;
        hbd_mbc1_pkg::t_rsp res;
        a = q.bus_address; d = q.write_byte; wr = q.req_type;
        res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0, 8'd0);
        if (a <= 16'h7FFF) begin
            if (wr) begin
                if (a <= 16'h1FFF) ram_en = d[3:0];
                else if (a <= 16'h3FFF) begin
                    v = {3'b0, d[4:0]};
                    if (v == 8'd0) v = 8'd1;
                    rom_bank = (rom_bank & 8'hE0) | v;
                end else if (a <= 16'h5FFF) ram_bank = d[1:0];
            end else if (boot_on && a <= 16'h00FF)
                res = mk(hbd_mbc1_pkg::TGT_BOOT, {6'd0, a}, 1'b0, 8'd0);
            else if (a <= 16'h3FFF || !mapper_q)
                res = mk(hbd_mbc1_pkg::TGT_ROM, {6'd0, a}, 1'b0, 8'd0);
            else begin
                bank = {3'b0, rom_bank[4:0]};
                if (mode_q) bank[6:5] = ram_bank;
                if (bank[4:0] == 5'd0) bank = bank + 8'd1;
                res = mk(hbd_mbc1_pkg::TGT_ROM,
                         22'(a - 16'h4000) + 22'(bank) * 22'h4000, 1'b0, 8'd0);
            end
        end else if (a <= 16'h9FFF) begin
            if (q.vram_locked)
                res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0,
                         wr ? 8'h00 : hbd_mbc1_pkg::BYTE_FF);
            else res = mk(hbd_mbc1_pkg::TGT_VRAM, 22'(a - 16'h8000), wr, 8'd0);
        end else if (a <= 16'hBFFF) begin
            if (ram_en != hbd_mbc1_pkg::RAM_EN_KEY)
                res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0,
                         wr ? 8'h00 : hbd_mbc1_pkg::BYTE_FF);
            else res = mk(hbd_mbc1_pkg::TGT_CRAM,
                          22'(a - 16'hA000) + (mode_q ? 22'(ram_bank) * 22'h2000 : 22'd0),
                          wr, 8'd0);
        end else if (a <= 16'hDFFF)
            res = mk(hbd_mbc1_pkg::TGT_WRAM, 22'(a - 16'hC000), wr, 8'd0);
        else if (a <= 16'hFDFF)
            res = mk(hbd_mbc1_pkg::TGT_WRAM, 22'(a - 16'hE000), wr, 8'd0);
        else if (a <= 16'hFE9F) begin
            if (q.oam_locked)
                res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0,
                         wr ? 8'h00 : hbd_mbc1_pkg::BYTE_FF);
            else res = mk(hbd_mbc1_pkg::TGT_OAM, 22'(a - 16'hFE00), wr, 8'd0);
        end else if (a <= 16'hFEFF)
            res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0,
                     wr ? 8'h00 : hbd_mbc1_pkg::BYTE_FF);
        else if (a <= 16'hFF7F) begin
            r = a[6:0];
            if (!wr) begin
                if (r == hbd_mbc1_pkg::IO_JOYP) begin
                    v = io_regs[hbd_mbc1_pkg::IO_JOYP] | 8'h0F;
                    if (!io_regs[hbd_mbc1_pkg::IO_JOYP][4]) v &= q.direction_keys;
                    if (!io_regs[hbd_mbc1_pkg::IO_JOYP][5]) v &= q.action_keys;
                    v |= 8'hC0;
                end else v = io_regs[r];
                res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0, v);
            end else if (r == hbd_mbc1_pkg::IO_JOYP)
                io_regs[hbd_mbc1_pkg::IO_JOYP] = (io_regs[hbd_mbc1_pkg::IO_JOYP] & 8'h0F)
                                                 | (d & 8'h30) | 8'hC0;
            else if (r == hbd_mbc1_pkg::IO_SC) begin
                io_regs[hbd_mbc1_pkg::IO_SC] = d;
                if (d[7]) begin
                    io_regs[hbd_mbc1_pkg::IO_SC] = d & 8'h7F;
                    io_regs[hbd_mbc1_pkg::IO_IF] |= 8'h08;
                end
            end else if (r == hbd_mbc1_pkg::IO_BOOT) boot_on = 1'b0;
            else io_regs[r] = d;
        end else if (a <= 16'hFFFE) begin
            if (wr) hram[a[6:0]] = d;
            else res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0, hram[a[6:0]]);
        end else begin
            if (wr) ie_reg = d;
            else res = mk(hbd_mbc1_pkg::TGT_NONE, 22'd0, 1'b0, ie_reg);
        end
        return res;
    endfunction

    // Track state, queue expectations and compare result words
    always @(posedge i_clk) begin
        hbd_mbc1_pkg::t_rsp e;
        if (!i_rst_n) begin
            mode_q = 1'b0; mapper_q = 1'b1; rom_bank = 8'd0; ram_bank = 2'd0;
            ram_en = 4'd0; boot_on = 1'b1; ie_reg = 8'd0;
            foreach (io_regs[k]) io_regs[k] = 8'd0;
            foreach (hram[k]) hram[k] = 8'd0;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == hbd_mbc1_pkg::CFG_BANK_MODE) mode_q = i_cfg_data;
                else mapper_q = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) expected_words.push_back(decode_access(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (e !== i_out_data) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/handheld_bus_decoder_mbc1_test.sv
// Stimulus and verdict for the MBC1 bus decoder.
module handheld_bus_decoder_mbc1_test;

    logic i_clk, i_rst_n, i_cfg_we, i_cfg_index, i_cfg_data;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    hbd_mbc1_pkg::t_req i_in_data;
    hbd_mbc1_pkg::t_rsp o_out_data;
    int   fail_count, pending, idle_cycles;
    bit   stall_on;

    handheld_bus_decoder_mbc1 uut (.*);

    handheld_bus_decoder_mbc1_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stalls in runs, with long stall-free stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
        i_out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("handheld_bus_decoder_mbc1_test: errors");
            $finish;
        end
    end

    // Present one word and hold until accepted
    task automatic send_word(hbd_mbc1_pkg::t_req q);
        i_in_valid <= 1;
        i_in_data  <= q;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic gap();
        i_in_valid <= 0;
        repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    function automatic hbd_mbc1_pkg::t_req rand_word(logic w, logic [15:0] a);
        hbd_mbc1_pkg::t_req q;
        q.req_type = w; q.bus_address = a; q.write_byte = 8'($urandom);
        q.vram_locked = 1'($urandom); q.oam_locked = 1'($urandom);
        q.direction_keys = 8'($urandom); q.action_keys = 8'($urandom);
        return q;
    endfunction

    // Pick an address biased toward interesting regions
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(16'h0000, 16'h7FFF));
            1: return 16'($urandom_range(16'h0000, 16'h00FF));
            2: return 16'($urandom_range(16'h8000, 16'h9FFF));
            3: return 16'($urandom_range(16'hA000, 16'hBFFF));
            4: return 16'($urandom_range(16'hC000, 16'hFDFF));
            5: return 16'($urandom_range(16'hFE00, 16'hFEFF));
            6: return 16'($urandom_range(16'hFF00, 16'hFF7F));
            7: return 16'($urandom_range(16'hFF80, 16'hFFFF));
            8: return {9'h1FE, 7'($urandom_range(0, 3) == 0 ? 7'h50 : 7'($urandom_range(0, 15)))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Wait until every result has come back, then let the pipe drain
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_phase(int n);
        hbd_mbc1_pkg::t_req q;
        int   burst;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                gap();
                burst = $urandom_range(1, 20);
            end
            q = rand_word(1'($urandom), pick_addr());
            // Unlock RAM fairly often so banked RAM is reached
            if ($urandom_range(0, 7) == 0) begin
                q.req_type = 1; q.bus_address = 16'($urandom_range(0, 16'h1FFF));
                q.write_byte = ($urandom_range(0, 2) != 0) ? 8'h0A : 8'($urandom);
            end
            send_word(q);
            burst--;
        end
    endtask

    initial begin
        hbd_mbc1_pkg::t_req q;
        logic [15:0] dir_addr [] = '{16'h0000, 16'h00FF, 16'h0100, 16'h3FFF, 16'h4000,
                                     16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF,
                                     16'hC000, 16'hE000, 16'hFDFF, 16'hFE9F, 16'hFEA0,
                                     16'hFF00, 16'hFF02, 16'hFF0F, 16'hFF80, 16'hFFFE,
                                     16'hFFFF};
        i_in_valid = 0; i_in_data = '0;
        i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: region edges as reads, then bank and special register writes
        foreach (dir_addr[k]) send_word(rand_word(1'b0, dir_addr[k]));
        q = rand_word(1'b1, 16'h2000); q.write_byte = 8'h00; send_word(q);
        q = rand_word(1'b1, 16'h0000); q.write_byte = 8'hFA; send_word(q);
        q = rand_word(1'b1, 16'h4000); q.write_byte = 8'hFF; send_word(q);
        q = rand_word(1'b1, 16'hFF02); q.write_byte = 8'hFF; send_word(q);
        q = rand_word(1'b1, 16'hFF00); q.write_byte = 8'hFF; send_word(q);
        drain();

        // Random phases across configuration settings
        for (int p = 0; p < 4; p++) begin
            write_cfg(hbd_mbc1_pkg::CFG_BANK_MODE, p[0]);
            write_cfg(hbd_mbc1_pkg::CFG_HAS_MAPPER, ~p[1]);
            random_phase(170);
            drain();
        end

        if (fail_count == 0) $display("handheld_bus_decoder_mbc1_test: clean");
        else $display("handheld_bus_decoder_mbc1_test: errors");
        $finish;
    end
endmodule
